// ===== sv/icrc_pkg.sv =====
// Shared types, constants and register map for the crop-and-rotate core.
package icrc_pkg;

  localparam int MAX_DIM = 256;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * DIM_W;
  // compare width: holds a position plus one and any sum of two register fields
  localparam int CMP_W   = DIM_W + 2;
  localparam int PIX_W   = 24;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_WINDOW = 2'd1;
  localparam logic [1:0] STATUS_NOT_READY  = 2'd2;

  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WINDOW_LEFT   = 3'd2;
  localparam logic [2:0] REG_WINDOW_TOP    = 3'd3;
  localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd4;
  localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd5;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel_in;
  } cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_pixel;
    logic [1:0]       status;
  } result_t;

  typedef struct packed {
    logic [8:0] source_width;
    logic [8:0] source_height;
    logic [7:0] window_left;
    logic [7:0] window_top;
    logic [8:0] window_width;
    logic [8:0] window_height;
  } cfg_t;

endpackage

// ===== sv/icrc_fbuf.sv =====
// Frame buffer: single-port synchronous RAM with registered read data.
module icrc_fbuf
  import icrc_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [PIX_W-1:0]  wdata,
  output logic [PIX_W-1:0]  q
);

  logic [PIX_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      q <= mem[addr];
    end
  end

endmodule

// ===== sv/icrc_regs.sv =====
// APB configuration registers for the crop window and source size.
module icrc_regs
  import icrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= 9'd256;
      cfg.source_height <= 9'd256;
      cfg.window_left   <= 8'd0;
      cfg.window_top    <= 8'd0;
      cfg.window_width  <= 9'd256;
      cfg.window_height <= 9'd256;
    end else if (wr) begin
      unique case (idx)
        REG_SOURCE_WIDTH:  cfg.source_width  <= pwdata[8:0];
        REG_SOURCE_HEIGHT: cfg.source_height <= pwdata[8:0];
        REG_WINDOW_LEFT:   cfg.window_left   <= pwdata[7:0];
        REG_WINDOW_TOP:    cfg.window_top    <= pwdata[7:0];
        REG_WINDOW_WIDTH:  cfg.window_width  <= pwdata[8:0];
        REG_WINDOW_HEIGHT: cfg.window_height <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SOURCE_WIDTH:  prdata = {23'd0, cfg.source_width};
      REG_SOURCE_HEIGHT: prdata = {23'd0, cfg.source_height};
      REG_WINDOW_LEFT:   prdata = {24'd0, cfg.window_left};
      REG_WINDOW_TOP:    prdata = {24'd0, cfg.window_top};
      REG_WINDOW_WIDTH:  prdata = {23'd0, cfg.window_width};
      REG_WINDOW_HEIGHT: prdata = {23'd0, cfg.window_height};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/icrc_ctrl.sv =====
// Load/fetch sequencer: position counters, buffer addressing, result stage.
module icrc_ctrl
  import icrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  cmd_t              cmd,
  input  cfg_t              cfg,
  input  logic [PIX_W-1:0]  ram_q,
  output logic              ram_we,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_addr,
  output logic              done,
  output result_t           result
);

  logic [DIM_W-1:0] load_row, load_row_next;
  logic [DIM_W-1:0] load_column, load_column_next;
  logic             frame_complete, frame_complete_next;
  logic [DIM_W-1:0] emit_row, emit_row_next;
  logic [DIM_W-1:0] emit_column, emit_column_next;

  logic       res_valid;
  logic       res_from_ram;
  logic       res_last;
  logic [1:0] res_status;
  logic       res_from_ram_next;
  logic       res_last_next;
  logic [1:0] res_status_next;

  logic [CMP_W-1:0] sw, sh, wl, wt, ww, wh;
  logic [CMP_W-1:0] lrow, lcol, lcol_inc, lrow_inc, ecol_inc, erow_inc;
  logic [CMP_W-1:0] src_r;
  logic             win_ok, in_window;
  logic [DIM_W-1:0] crop_r, crop_c;

  assign sw = CMP_W'(cfg.source_width);
  assign sh = CMP_W'(cfg.source_height);
  assign wl = CMP_W'(cfg.window_left);
  assign wt = CMP_W'(cfg.window_top);
  assign ww = CMP_W'(cfg.window_width);
  assign wh = CMP_W'(cfg.window_height);

  assign win_ok = (sw != '0) && (sw <= CMP_W'(MAX_DIM)) &&
                  (sh != '0) && (sh <= CMP_W'(MAX_DIM)) &&
                  (ww != '0) && (wh != '0) &&
                  (wl + ww <= sw) && (wt + wh <= sh);

  assign lrow     = CMP_W'(load_row);
  assign lcol     = CMP_W'(load_column);
  assign lcol_inc = lcol + CMP_W'(1);
  assign lrow_inc = lrow + CMP_W'(1);
  assign ecol_inc = CMP_W'(emit_column) + CMP_W'(1);
  assign erow_inc = CMP_W'(emit_row) + CMP_W'(1);

  assign in_window = (lrow >= wt) && (lrow < wt + wh) && (lcol >= wl) && (lcol < wl + ww);
  assign crop_r    = DIM_W'(lrow - wt);
  assign crop_c    = DIM_W'(lcol - wl);
  assign src_r     = wh - CMP_W'(1) - CMP_W'(emit_column);

  always_comb begin
    load_row_next       = load_row;
    load_column_next    = load_column;
    frame_complete_next = frame_complete;
    emit_row_next       = emit_row;
    emit_column_next    = emit_column;
    res_from_ram_next   = 1'b0;
    res_last_next       = 1'b0;
    res_status_next     = STATUS_OK;
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    ram_addr            = {DIM_W'(src_r), emit_row};

    if (take && cmd.op == OP_LOAD) begin
      ram_addr = {crop_r, crop_c};
      if (win_ok && !frame_complete) begin
        ram_we = in_window;
        if (lcol_inc >= sw) begin
          load_column_next = '0;
          if (lrow_inc >= sh) begin
            load_row_next       = '0;
            frame_complete_next = 1'b1;
          end else begin
            load_row_next = DIM_W'(lrow_inc);
          end
        end else begin
          load_column_next = DIM_W'(lcol_inc);
        end
      end
    end else if (take) begin
      if (!win_ok) begin
        res_status_next = STATUS_BAD_WINDOW;
      end else if (!frame_complete) begin
        res_status_next = STATUS_NOT_READY;
      end else begin
        ram_re            = 1'b1;
        res_from_ram_next = 1'b1;
        if (ecol_inc >= wh) begin
          emit_column_next = '0;
          res_last_next    = (erow_inc >= ww);
          emit_row_next    = DIM_W'(erow_inc);
        end else begin
          emit_column_next = DIM_W'(ecol_inc);
          res_last_next    = (CMP_W'(emit_row) >= ww);
        end
        if (res_last_next) begin
          emit_row_next       = '0;
          emit_column_next    = '0;
          frame_complete_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_row       <= '0;
      load_column    <= '0;
      frame_complete <= 1'b0;
      emit_row       <= '0;
      emit_column    <= '0;
      res_valid      <= 1'b0;
    end else begin
      load_row       <= load_row_next;
      load_column    <= load_column_next;
      frame_complete <= frame_complete_next;
      emit_row       <= emit_row_next;
      emit_column    <= emit_column_next;
      res_valid      <= take && (cmd.op == OP_FETCH);
    end
  end

  always_ff @(posedge clk) begin
    res_from_ram <= res_from_ram_next;
    res_last     <= res_last_next;
    res_status   <= res_status_next;
  end

  assign done              = res_valid;
  assign result.pixel_out  = res_from_ram ? ram_q : '0;
  assign result.last_pixel = res_last;
  assign result.status     = res_status;

endmodule

// ===== sv/image_crop_rotate_clockwise_core.sv =====
// Top level of the crop and rotate-clockwise core.
// A fetch word returns its result in the cycle after acceptance (done high
// for that one cycle); a load word returns nothing. Throughput: one word per
// cycle, loads and fetches mixed freely; busy stays low as the single frame
// buffer port serves one write or one read per word. Reset (rst, synchronous)
// clears the counters, the frame-complete flag and registers; buffer contents
// are left as they are, and nothing may stall the result side.
module image_crop_rotate_clockwise_core
  import icrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  cmd,
  output logic                  done,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t              cfg;
  logic              take;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_q;

  // each word needs one buffer access, so the core never holds off a word
  assign busy = 1'b0;
  assign take = start & ~busy;

  icrc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a load written to an entry is visible to a fetch read of it in the next cycle,
  // so back-to-back accesses to the same entry need no forwarding
  icrc_fbuf u_fbuf (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (cmd.pixel_in),
    .q     (ram_q)
  );

  icrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .cmd      (cmd),
    .cfg      (cfg),
    .ram_q    (ram_q),
    .ram_we   (ram_we),
    .ram_re   (ram_re),
    .ram_addr (ram_addr),
    .done     (done),
    .result   (result)
  );

endmodule
